// ===== design/mcr_pkg.sv =====
// Shared opcodes, pixel sequencing constants and mirror decode for the circle rasterizer.
`default_nettype none

package mcr_pkg;

	// Command opcodes on the input word
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Pixels per octant point and the pixel index counter
	localparam int PIX_PER_POINT = 8;
	localparam int IDX_W = $clog2(PIX_PER_POINT);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PIX_PER_POINT - 1);

	// How one mirrored pixel is formed from the octant point
	typedef struct packed {
		logic swap;   // use y for the x offset and x for the y offset
		logic neg_x;  // subtract the x offset from the center
		logic neg_y;  // subtract the y offset from the center
	} mirror_t;

	// Pixel order: (-x,-y) (-y,-x) (-x,+y) (-y,+x) (+x,-y) (+y,-x) (+x,+y) (+y,+x)
	function automatic mirror_t mirror_of(logic [IDX_W-1:0] idx);
		mirror_t m;
		m.swap  = idx[0];
		m.neg_x = ~idx[2];
		m.neg_y = ~idx[1];
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== design/mcr_front.sv =====
// Front end: accepts start and step words, runs the midpoint recurrence, queues octant points.
`default_nettype none

module mcr_front import mcr_pkg::*; #(
	parameter int COORD_WIDTH  = 12,
	parameter int RADIUS_WIDTH = 10,
	parameter int ENTRY_W      = 2 * COORD_WIDTH + 2 * (RADIUS_WIDTH + 1) + 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           opcode,
	input  wire logic signed [COORD_WIDTH-1:0]  center_x,
	input  wire logic signed [COORD_WIDTH-1:0]  center_y,
	input  wire logic        [RADIUS_WIDTH-1:0] radius,
	input  wire logic                           q_full,
	output logic                                q_push,
	output logic             [ENTRY_W-1:0]      q_wdata
);

	localparam int OW = RADIUS_WIDTH + 1;  // octant coordinate, signed (y can reach -1)
	localparam int DW = RADIUS_WIDTH + 4;  // decision value, signed

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic signed [OW-1:0]          x;
		logic signed [OW-1:0]          y;
		logic                          done;
	} entry_t;

	logic signed [COORD_WIDTH-1:0] held_cx_q;
	logic signed [COORD_WIDTH-1:0] held_cy_q;
	logic signed [OW-1:0]          oct_x_q;
	logic signed [OW-1:0]          oct_y_q;
	logic signed [DW-1:0]          decision_q;
	logic                          active_q;

	logic                 accept;
	logic                 is_start;
	logic                 is_step;
	logic signed [OW-1:0] x_nxt;
	logic signed [OW-1:0] y_nxt;
	logic signed [DW-1:0] d_nxt;
	logic signed [DW-1:0] x_term;
	logic signed [DW-1:0] y_term;
	logic                 done_nxt;
	logic signed [OW-1:0] r_ext;
	entry_t               entry;

	assign in_stall = q_full;
	assign accept   = in_valid & ~in_stall;
	assign r_ext    = $signed({1'b0, radius});
	assign is_start = (opcode == OP_START);
	assign is_step  = (opcode == OP_STEP) && active_q && !(oct_x_q > oct_y_q);

	// One octant step of the midpoint recurrence
	always_comb begin
		x_nxt  = oct_x_q + OW'(1);
		x_term = ($signed({{(DW-OW){x_nxt[OW-1]}}, x_nxt}) <<< 1) + DW'(1);
		if (decision_q[DW-1]) begin
			y_nxt  = oct_y_q;
			y_term = '0;
		end else begin
			y_nxt  = oct_y_q - OW'(1);
			y_term = $signed({{(DW-OW){y_nxt[OW-1]}}, y_nxt}) <<< 1;
		end
		d_nxt    = decision_q + x_term - y_term;
		done_nxt = x_nxt > y_nxt;
	end

	// Point word handed to the back end
	always_comb begin
		if (is_start) begin
			entry.cx   = center_x;
			entry.cy   = center_y;
			entry.x    = '0;
			entry.y    = r_ext;
			entry.done = 1'b0;
		end else begin
			entry.cx   = held_cx_q;
			entry.cy   = held_cy_q;
			entry.x    = x_nxt;
			entry.y    = y_nxt;
			entry.done = done_nxt;
		end
	end

	assign q_push  = accept & (is_start | is_step);
	assign q_wdata = entry;

	// Circle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cx_q  <= '0;
			held_cy_q  <= '0;
			oct_x_q    <= '0;
			oct_y_q    <= '0;
			decision_q <= '0;
			active_q   <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				held_cx_q  <= center_x;
				held_cy_q  <= center_y;
				oct_x_q    <= '0;
				oct_y_q    <= r_ext;
				decision_q <= DW'(1) - $signed({{(DW-OW){1'b0}}, r_ext});
				active_q   <= 1'b1;
			end else if (is_step) begin
				oct_x_q    <= x_nxt;
				oct_y_q    <= y_nxt;
				decision_q <= d_nxt;
				active_q   <= ~done_nxt;
			end else begin
				active_q   <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/mcr_queue.sv =====
// Two-entry queue of octant points between the front and back ends.
`default_nettype none

module mcr_queue #(
	parameter int WIDTH = 45
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/mcr_back.sv =====
// Back end: walks the eight mirrored pixels of the head point, one per cycle while out_stall is low.
`default_nettype none

module mcr_back import mcr_pkg::*; #(
	parameter int COORD_WIDTH  = 12,
	parameter int RADIUS_WIDTH = 10,
	parameter int ENTRY_W      = 2 * COORD_WIDTH + 2 * (RADIUS_WIDTH + 1) + 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic        [ENTRY_W-1:0]     q_rdata,
	input  wire logic                          q_empty,
	output logic                               q_pop,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed      [COORD_WIDTH:0]   pixel_x,
	output logic signed      [COORD_WIDTH:0]   pixel_y,
	output logic                               last_of_point,
	output logic                               circle_done
);

	localparam int OW = RADIUS_WIDTH + 1;
	localparam int SW = ((COORD_WIDTH > OW) ? COORD_WIDTH : OW) + 1;  // sum width

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] cx;
		logic signed [COORD_WIDTH-1:0] cy;
		logic signed [OW-1:0]          x;
		logic signed [OW-1:0]          y;
		logic                          done;
	} entry_t;

	entry_t             head;
	logic [IDX_W-1:0]   idx_q;
	logic               out_accept;
	mirror_t            mir;
	logic signed [OW-1:0] off_a;
	logic signed [OW-1:0] off_b;
	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;
	logic signed [SW-1:0] ext_a;
	logic signed [SW-1:0] ext_b;

	assign head       = q_rdata;
	assign out_valid  = ~q_empty;
	assign out_accept = out_valid & ~out_stall;
	assign q_pop      = out_accept && (idx_q == IDX_LAST);

	// Mirror the octant point about the held center
	always_comb begin
		mir   = mirror_of(idx_q);
		off_a = mir.swap ? head.y : head.x;
		off_b = mir.swap ? head.x : head.y;
		ext_a = $signed({{(SW-OW){off_a[OW-1]}}, off_a});
		ext_b = $signed({{(SW-OW){off_b[OW-1]}}, off_b});
		sum_x = $signed({{(SW-COORD_WIDTH){head.cx[COORD_WIDTH-1]}}, head.cx})
			+ (mir.neg_x ? -ext_a : ext_a);
		sum_y = $signed({{(SW-COORD_WIDTH){head.cy[COORD_WIDTH-1]}}, head.cy})
			+ (mir.neg_y ? -ext_b : ext_b);
	end

	assign pixel_x       = sum_x[COORD_WIDTH:0];
	assign pixel_y       = sum_y[COORD_WIDTH:0];
	assign last_of_point = (idx_q == IDX_LAST);
	assign circle_done   = last_of_point & head.done;

	// Pixel index within the current point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_accept) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== design/midpoint_circle_rasterizer.sv =====
// Top level of the midpoint circle rasterizer: front end, point queue and pixel sequencer.
`default_nettype none

// A start word (opcode 0) loads center and radius and yields the eight mirrored
// pixels of the point (0, r); each step word (opcode 1) advances the octant walk one
// point and yields its eight pixels, with last_of_point on the eighth and circle_done
// on the eighth of the point that ends the walk. Steps after the walk has ended, or
// with no circle loaded, yield nothing. Input words are taken one per cycle into a
// two-entry point queue while it is not full; each point then occupies the result
// channel for its eight pixels, one pixel per cycle from the back-end sequencer while
// out_stall is low. Words that yield nothing push no queue entry. No clearing pass
// after reset.
module midpoint_circle_rasterizer import mcr_pkg::*; #(
	parameter int COORD_WIDTH  = 12,
	parameter int RADIUS_WIDTH = 10
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           opcode,
	input  wire logic signed [COORD_WIDTH-1:0]  center_x,
	input  wire logic signed [COORD_WIDTH-1:0]  center_y,
	input  wire logic        [RADIUS_WIDTH-1:0] radius,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed      [COORD_WIDTH:0]    pixel_x,
	output logic signed      [COORD_WIDTH:0]    pixel_y,
	output logic                                last_of_point,
	output logic                                circle_done
);

	localparam int ENTRY_W = 2 * COORD_WIDTH + 2 * (RADIUS_WIDTH + 1) + 1;

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	logic [ENTRY_W-1:0] q_wdata;
	logic [ENTRY_W-1:0] q_rdata;

	mcr_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.RADIUS_WIDTH(RADIUS_WIDTH),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode  (opcode),
		.center_x(center_x),
		.center_y(center_y),
		.radius  (radius),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	mcr_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	mcr_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.RADIUS_WIDTH(RADIUS_WIDTH),
		.ENTRY_W     (ENTRY_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_rdata      (q_rdata),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_of_point(last_of_point),
		.circle_done  (circle_done)
	);

endmodule

`default_nettype wire

// ===== design/mcr_checker.sv =====
// Port-level assertions for the circle rasterizer, bound to the top level.
`default_nettype none

module mcr_checker import mcr_pkg::*; #(
	parameter int COORD_WIDTH = 12
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic signed [COORD_WIDTH:0] pixel_x,
	input wire logic signed [COORD_WIDTH:0] pixel_y,
	input wire logic                        last_of_point,
	input wire logic                        circle_done
);

	logic [IDX_W-1:0] seen_q;

	// Count delivered pixels within a point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (out_valid && !out_stall) begin
			seen_q <= seen_q + IDX_W'(1);
		end
	end

	// Nothing is offered while reset is applied
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

	// A stalled pixel stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(last_of_point) && $stable(circle_done))
		else $error("stalled pixel changed");

	// Every eighth delivered pixel closes a point
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_point == (seen_q == IDX_LAST)))
		else $error("last_of_point out of step with the pixel count");

	// Walk end is flagged only on the closing pixel
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && circle_done |-> last_of_point)
		else $error("circle_done away from the last pixel of a point");

endmodule

bind midpoint_circle_rasterizer mcr_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_mcr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.pixel_x      (pixel_x),
	.pixel_y      (pixel_y),
	.last_of_point(last_of_point),
	.circle_done  (circle_done)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the midpoint circle rasterizer: directed table, then random words.
module tb_top import mcr_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 12;
	localparam int RW = 10;
	localparam logic signed [CW-1:0] CMAX = 12'sh7ff;
	localparam logic signed [CW-1:0] CMIN = 12'sh800;
	localparam logic [RW-1:0] RMAX = 10'h3ff;
	localparam int PHASE_WORDS = 150;
	localparam int TAIL_CYCLES = 20;

	// How the pixels of a word are known: from the circle predictor, typed in, or none expected
	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_CENTER} exp_kind_t;

	typedef struct packed {
		logic signed [CW:0] px;
		logic signed [CW:0] py;
		logic last;
		logic done;
	} pixel_t;

	typedef struct packed {
		logic op;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [RW-1:0] r;
		exp_kind_t kind;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic opcode = OP_START;
	logic signed [CW-1:0] center_x = '0;
	logic signed [CW-1:0] center_y = '0;
	logic [RW-1:0] radius = '0;
	logic out_stall = 1'b0;
	exp_kind_t word_kind = EXP_MODEL;
	wire in_stall;
	wire out_valid;
	wire signed [CW:0] pixel_x;
	wire signed [CW:0] pixel_y;
	wire last_of_point;
	wire circle_done;

	int send_idle_pct = 35;
	int recv_stall_pct = 62;
	int mismatches = 0;

	// Predictor copy of the circle state
	logic signed [CW-1:0] cen_x = '0;
	logic signed [CW-1:0] cen_y = '0;
	logic signed [CW-1:0] oct_x = '0;
	logic signed [CW-1:0] oct_y = '0;
	logic signed [13:0] dec = '0;
	logic walking = 1'b0;

	pixel_t fresh_q[$];
	pixel_t pixel_q[$];

	// Directed words: extremes, abandon, radius zero, steps when idle or finished
	dir_row_t dir_rows [0:23] = '{
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_NONE},
		'{OP_START, 12'sh000, 12'sh000, 10'd0,   EXP_CENTER},
		'{OP_STEP,  CMAX,     CMIN,     RMAX,    EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_NONE},
		'{OP_START, CMAX,     CMAX,     RMAX,    EXP_MODEL},
		'{OP_STEP,  CMIN,     CMIN,     10'd0,   EXP_MODEL},
		'{OP_STEP,  CMAX,     CMAX,     RMAX,    EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_MODEL},
		'{OP_START, CMIN,     CMIN,     RMAX,    EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_MODEL},
		'{OP_START, CMIN,     CMAX,     10'd0,   EXP_CENTER},
		'{OP_START, CMAX,     CMIN,     10'd5,   EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_NONE},
		'{OP_START, 12'sh555, 12'shaaa, 10'h2aa, EXP_MODEL},
		'{OP_START, 12'shaaa, 12'sh555, 10'h155, EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_MODEL},
		'{OP_START, 12'sh000, 12'sh000, 10'd1,   EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_MODEL},
		'{OP_STEP,  12'sh000, 12'sh000, 10'd0,   EXP_NONE}
	};

	midpoint_circle_rasterizer #(
		.COORD_WIDTH(CW),
		.RADIUS_WIDTH(RW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.last_of_point(last_of_point),
		.circle_done(circle_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic pixel_t make_pixel(logic signed [CW:0] px, logic signed [CW:0] py,
			logic last, logic done);
		pixel_t p;
		p.px = px;
		p.py = py;
		p.last = last;
		p.done = done;
		return p;
	endfunction

	// Eight mirrors of the current octant point, fixed order
	task automatic emit_mirrors(input logic done);
		logic signed [CW:0] ex, ey, ox, oy;
		logic signed [CW:0] mx [8];
		logic signed [CW:0] my [8];
		ex = cen_x;
		ey = cen_y;
		ox = oct_x;
		oy = oct_y;
		mx[0] = ex - ox; my[0] = ey - oy;
		mx[1] = ex - oy; my[1] = ey - ox;
		mx[2] = ex - ox; my[2] = ey + oy;
		mx[3] = ex - oy; my[3] = ey + ox;
		mx[4] = ex + ox; my[4] = ey - oy;
		mx[5] = ex + oy; my[5] = ey - ox;
		mx[6] = ex + ox; my[6] = ey + oy;
		mx[7] = ex + oy; my[7] = ey + ox;
		for (int k = 0; k < 8; k++)
			fresh_q.push_back(make_pixel(mx[k], my[k], k == 7, (k == 7) && done));
	endtask

	// Circle walk predictor: one accepted word in, its pixels into fresh_q
	task automatic advance_circle(input logic op, input logic signed [CW-1:0] cx,
			input logic signed [CW-1:0] cy, input logic [RW-1:0] r);
		logic fin;
		fresh_q.delete();
		if (op == OP_START) begin
			cen_x = cx;
			cen_y = cy;
			oct_x = '0;
			oct_y = $signed({2'b00, r});
			dec = 14'sd1 - $signed({4'b0000, r});
			walking = 1'b1;
			emit_mirrors(1'b0);
		end else if (walking && !(oct_x > oct_y)) begin
			oct_x = oct_x + 1;
			if (dec < 0) begin
				dec = dec + 2 * oct_x + 1;
			end else begin
				oct_y = oct_y - 1;
				dec = dec + 2 * oct_x + 1 - 2 * oct_y;
			end
			fin = oct_x > oct_y;
			emit_mirrors(fin);
			if (fin)
				walking = 1'b0;
		end else begin
			walking = 1'b0;
		end
	endtask

	function automatic void check_field(string name, logic signed [CW:0] want,
			logic signed [CW:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Scoreboard: predict on input acceptance, compare on output acceptance
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				advance_circle(opcode, center_x, center_y, radius);
				case (word_kind)
					EXP_MODEL: begin
						foreach (fresh_q[i])
							pixel_q.push_back(fresh_q[i]);
					end
					EXP_CENTER: begin
						for (int k = 0; k < 8; k++)
							pixel_q.push_back(make_pixel(center_x, center_y, k == 7, 1'b0));
					end
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: unexpected pixel x=%0d y=%0d last=%0b done=%0b",
						$time, pixel_x, pixel_y, last_of_point, circle_done);
					mismatches++;
				end else begin
					want = pixel_q.pop_front();
					check_field("pixel_x", want.px, pixel_x);
					check_field("pixel_y", want.py, pixel_y);
					check_field("last_of_point", want.last, last_of_point);
					check_field("circle_done", want.done, circle_done);
				end
			end
		end
	end

	// Receiver back-pressure
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Drive one word after a random idle gap and hold it until taken
	task automatic send_word(input logic op, input logic signed [CW-1:0] cx,
			input logic signed [CW-1:0] cy, input logic [RW-1:0] r, input exp_kind_t kind);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		center_x <= cx;
		center_y <= cy;
		radius <= r;
		word_kind <= kind;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold off the sender until every pending pixel has arrived
	task automatic drain();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		return CW'($urandom);
	endfunction

	// Mostly small radii keep walks short; a few span the full range
	function automatic logic [RW-1:0] rand_radius();
		int pick;
		pick = $urandom_range(99);
		if (pick < 85)
			return RW'($urandom_range(15));
		else if (pick < 95)
			return RW'($urandom_range(63));
		return RW'($urandom);
	endfunction

	initial begin
		int sent;
		int cap;
		int steps;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table
		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].r,
				dir_rows[i].kind);
		drain();

		// Random: three idling profiles, a full drain between them
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 35; recv_stall_pct = 62; end
				1: begin send_idle_pct = 62; recv_stall_pct = 35; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			sent = 0;
			while (sent < PHASE_WORDS) begin
				if ($urandom_range(99) < 80) begin
					// start, walk (possibly cut short), then a few stray steps
					send_word(OP_START, rand_coord(), rand_coord(), rand_radius(), EXP_MODEL);
					sent++;
					cap = $urandom_range(1, 40);
					steps = 0;
					while (walking && steps < cap) begin
						send_word(OP_STEP, rand_coord(), rand_coord(), RW'($urandom), EXP_MODEL);
						steps++;
						sent++;
					end
					repeat ($urandom_range(2)) begin
						send_word(OP_STEP, rand_coord(), rand_coord(), RW'($urandom), EXP_MODEL);
						sent++;
					end
				end else begin
					send_word(1'($urandom), rand_coord(), rand_coord(), rand_radius(), EXP_MODEL);
					sent++;
				end
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
